// ----- rtl/assert_macros.svh -----
// Assertion helpers for the order book level update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define OBU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clk edge outside reset.
`define OBU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/obu_pkg.sv -----
package obu_pkg;

    localparam int BOOK_DEPTH = 8;
    localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

    localparam logic [7:0] CH_TYPE_BID  = 8'h30;
    localparam logic [7:0] CH_TYPE_ASK  = 8'h31;
    localparam logic [7:0] CH_TYPE_DBID = 8'h45;
    localparam logic [7:0] CH_TYPE_DASK = 8'h46;

    localparam logic [7:0] CH_ACT_NEW     = 8'h30;
    localparam logic [7:0] CH_ACT_CHANGE  = 8'h31;
    localparam logic [7:0] CH_ACT_DELETE  = 8'h32;
    localparam logic [7:0] CH_ACT_OVERLAY = 8'h35;

    typedef enum logic [1:0] {
        SIDE_BID  = 2'd0,
        SIDE_ASK  = 2'd1,
        SIDE_DBID = 2'd2,
        SIDE_DASK = 2'd3
    } side_t;

    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_DELETE = 2'd1,
        OP_CHANGE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ACT_NEW       = 2'd0,
        ACT_DELETE    = 2'd1,
        ACT_QTY       = 2'd2,
        ACT_PRICE_QTY = 2'd3
    } act_code_t;

    typedef struct packed {
        logic signed [31:0] price;
        logic        [31:0] qty;
    } level_t;

    typedef struct packed {
        logic               ok;
        side_t              side;
        op_t                op;
        logic        [3:0]  idx;
        logic signed [31:0] price;
        logic        [31:0] qty;
        logic        [3:0]  flags;
        logic        [7:0]  count;
    } item_t;

    typedef struct packed {
        logic               applied;
        side_t              side;
        act_code_t          act;
        logic        [3:0]  idx;
        logic signed [31:0] price;
        logic        [31:0] qty;
        logic        [3:0]  flags;
        logic        [7:0]  count;
    } result_t;

endpackage

// ----- rtl/obu_front.sv -----
module obu_front
    import obu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               first_of_message,
    input  logic        [7:0]  entry_type,
    input  logic        [7:0]  level,
    input  logic        [7:0]  update_action,
    input  logic signed [31:0] price,
    input  logic        [31:0] quantity,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    logic [3:0] flags_reg;
    logic [3:0] flags_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    logic       type_ok;
    side_t      side;
    logic [7:0] depth;
    logic       op_ok;
    op_t        op;
    logic       lvl_ok;
    logic       ok;
    logic [7:0] lvl_m1;
    logic [3:0] flags_base;
    logic [7:0] count_base;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        type_ok = 1'b1;
        side    = SIDE_BID;
        depth   = 8'(BOOK_DEPTH);
        unique case (entry_type)
            CH_TYPE_BID:  side = SIDE_BID;
            CH_TYPE_ASK:  side = SIDE_ASK;
            CH_TYPE_DBID:
            begin
                side  = SIDE_DBID;
                depth = 8'd1;
            end
            CH_TYPE_DASK:
            begin
                side  = SIDE_DASK;
                depth = 8'd1;
            end
            default:
            begin
                type_ok = 1'b0;
                depth   = 8'd0;
            end
        endcase

        op_ok = 1'b1;
        op    = OP_NEW;
        unique case (update_action)
            CH_ACT_NEW:     op = OP_NEW;
            CH_ACT_CHANGE:  op = OP_CHANGE;
            CH_ACT_OVERLAY: op = OP_CHANGE;
            CH_ACT_DELETE:  op = OP_DELETE;
            default:        op_ok = 1'b0;
        endcase

        lvl_ok = (level != 8'd0) && (level <= depth);
        ok     = type_ok && lvl_ok && op_ok;
        lvl_m1 = level - 8'd1;

        flags_base = first_of_message ? 4'd0 : flags_reg;
        count_base = first_of_message ? 8'd0 : count_reg;

        flags_next = flags_base;
        if (type_ok)
        begin
            flags_next[side] = 1'b1;
        end
        count_next = count_base;
        if (ok && (count_base != 8'hFF))
        begin
            count_next = count_base + 8'd1;
        end

        q_item.ok    = ok;
        q_item.side  = side;
        q_item.op    = op;
        q_item.idx   = ok ? lvl_m1[3:0] : 4'd0;
        q_item.price = price;
        q_item.qty   = quantity;
        q_item.flags = flags_next;
        q_item.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= 4'd0;
            count_reg <= 8'd0;
        end
        else if (q_push)
        begin
            flags_reg <= flags_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/obu_queue.sv -----
module obu_queue
    import obu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_push,
    input  item_t q_item,
    output logic  q_full,
    input  logic  q_pop,
    output logic  q_empty,
    output item_t q_head
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    item_t      slot0_reg;
    item_t      slot0_next;
    item_t      slot1_reg;
    item_t      slot1_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign q_head  = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        unique case ({q_push, q_pop})
            2'b10:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    slot0_next = q_item;
                end
                else
                begin
                    slot1_next = q_item;
                end
            end
            2'b01:
            begin
                cnt_next   = cnt_reg - 2'd1;
                slot0_next = slot1_reg;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    slot0_next = q_item;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = q_item;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- rtl/obu_back.sv -----
module obu_back
    import obu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  item_t   q_head,
    output logic    q_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    level_t  bid_reg  [BOOK_DEPTH];
    level_t  ask_reg  [BOOK_DEPTH];
    level_t  dbid_reg;
    level_t  dask_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    level_t           cur  [BOOK_DEPTH];
    level_t           upd  [BOOK_DEPTH];
    level_t           dcur;
    level_t           dupd;
    level_t           entry;
    level_t           res_level;
    logic [IDX_W-1:0] idx;
    logic             is_book;
    logic signed [31:0] old_price;
    result_t          res;
    logic             apply;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign q_pop  = !q_empty && (!out_valid_reg || pop);
    assign apply  = q_pop && q_head.ok;

    always_comb
    begin
        entry.price = q_head.price;
        entry.qty   = q_head.qty;
        idx         = q_head.idx[IDX_W-1:0];
        is_book     = (q_head.side == SIDE_BID) || (q_head.side == SIDE_ASK);

        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            cur[i] = (q_head.side == SIDE_ASK) ? ask_reg[i] : bid_reg[i];
        end
        upd = cur;

        unique case (q_head.op)
            OP_NEW:
            begin
                for (int i = 1; i < BOOK_DEPTH; i++)
                begin
                    if (IDX_W'(i) > idx)
                    begin
                        upd[i] = cur[i-1];
                    end
                end
                upd[idx] = entry;
            end
            OP_DELETE:
            begin
                for (int i = 0; i < BOOK_DEPTH - 1; i++)
                begin
                    if (IDX_W'(i) >= idx)
                    begin
                        upd[i] = cur[i+1];
                    end
                end
                upd[BOOK_DEPTH-1] = '0;
            end
            default:
            begin
                upd[idx] = entry;
            end
        endcase

        dcur = (q_head.side == SIDE_DASK) ? dask_reg : dbid_reg;
        dupd = (q_head.op == OP_DELETE) ? level_t'('0) : entry;

        old_price = is_book ? cur[idx].price : dcur.price;
        res_level = is_book ? upd[idx] : dupd;

        res = '0;
        if (q_head.ok)
        begin
            res.applied = 1'b1;
            res.side    = q_head.side;
            res.idx     = q_head.idx;
            res.price   = res_level.price;
            res.qty     = res_level.qty;
            unique case (q_head.op)
                OP_NEW:    res.act = ACT_NEW;
                OP_DELETE: res.act = ACT_DELETE;
                default:   res.act = (old_price == q_head.price) ? ACT_QTY : ACT_PRICE_QTY;
            endcase
        end
        res.flags = q_head.flags;
        res.count = q_head.count;

        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BOOK_DEPTH; i++)
            begin
                bid_reg[i] <= '0;
                ask_reg[i] <= '0;
            end
            dbid_reg      <= '0;
            dask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (apply)
            begin
                unique case (q_head.side)
                    SIDE_BID:  bid_reg  <= upd;
                    SIDE_ASK:  ask_reg  <= upd;
                    SIDE_DBID: dbid_reg <= dupd;
                    SIDE_DASK: dask_reg <= dupd;
                    default:   dbid_reg <= dbid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= res;
        end
    end

endmodule

// ----- rtl/order_book_level_update.sv -----
// Order book level update: keeps bid and ask books of BOOK_DEPTH price/quantity levels plus
// one derived bid and one derived ask, and applies one market-data word per cycle while no
// stall holds it, giving one result word for each input word (ignored entries included,
// with applied low). A taken word waits in the queue and is registered into the result
// register when the back stage pops it. A two-word queue between the classifying front stage
// and the book-update back stage lets either side stall; the level shift is combinational.
`include "assert_macros.svh"

module order_book_level_update
    import obu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               first_of_message,
    input  logic        [7:0]  entry_type,
    input  logic        [7:0]  level,
    input  logic        [7:0]  update_action,
    input  logic signed [31:0] price,
    input  logic        [31:0] quantity,
    output logic               empty,
    input  logic               pop,
    output logic               applied,
    output logic        [1:0]  side_code,
    output logic        [1:0]  action_code,
    output logic        [3:0]  level_index,
    output logic signed [31:0] out_price,
    output logic        [31:0] out_quantity,
    output logic        [3:0]  side_flags,
    output logic        [7:0]  update_count
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    item_t   q_item;
    item_t   q_head;
    result_t result;

    obu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .first_of_message (first_of_message),
        .entry_type       (entry_type),
        .level            (level),
        .update_action    (update_action),
        .price            (price),
        .quantity         (quantity),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_item)
    );

    obu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_item  (q_item),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    obu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign applied      = result.applied;
    assign side_code    = result.side;
    assign action_code  = result.act;
    assign level_index  = result.idx;
    assign out_price    = result.price;
    assign out_quantity = result.qty;
    assign side_flags   = result.flags;
    assign update_count = result.count;

    `OBU_ASSERT_IMP(a_ignored_zero, !empty && !applied,
        (side_code == 2'd0) && (action_code == 2'd0) && (level_index == 4'd0)
        && (out_price == 32'sd0) && (out_quantity == 32'd0), "ignored word carries payload")
    `OBU_ASSERT_IMP(a_level_range, !empty && applied,
        ({28'd0, level_index} < BOOK_DEPTH) && (!side_code[1] || (level_index == 4'd0)),
        "applied level outside its book")
    `OBU_ASSERT_IMP(a_flag_seen, !empty && applied,
        side_flags[side_code] && (update_count != 8'd0), "applied side not flagged or not counted")
    `OBU_ASSERT(a_queue_guard, !(q_pop && q_empty) && !(q_push && q_full),
        "queue overrun or underrun")

endmodule
